// ===== rtl/ptd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptd_pkg: constants and codes for the point taper deformer
// Field widths, fixed-point constants, register indexes and axis codes.
// ----------------------------------------------------------------------------
package ptd_pkg;

  // default coordinate width (signed, 16 fraction bits)
  localparam int COORD_WIDTH_DEF = 32;

  // fixed field widths
  localparam int FRAC_W   = 16;               // fraction bits of coordinates
  localparam int AMT_W    = 16;               // taper amount, signed Q2.14
  localparam int AMT_FRAC = 14;               // fraction bits of taper amount
  localparam int EXT_W    = 31;               // axis extent, unsigned Q15.16
  localparam int WGT_W    = 17;               // weight, unsigned Q1.16
  localparam int RATIO_W  = 16;               // quotient bits of the ratio
  localparam int SCALE_W  = 19;               // scale, signed Q.16
  localparam int TR_W     = AMT_W + RATIO_W + 2;  // taper times ratio product

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = EXT_W;

  // fixed-point constants
  localparam logic [WGT_W-1:0]   WGT_ONE   = WGT_W'(1 << FRAC_W);
  localparam logic [RATIO_W:0]   RATIO_ONE = (RATIO_W+1)'(1 << RATIO_W);
  localparam longint             SC_BIAS   = (64'sd1 << (FRAC_W + AMT_FRAC))
                                             + (64'sd1 << (AMT_FRAC - 1));
  localparam int                 HALF_LSB  = 1 << (FRAC_W - 1);

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAPER_AXIS   = 3'd0,
    REG_TAPER_AMOUNT = 3'd1,
    REG_AXIS_EXTENT  = 3'd2,
    REG_SCALE_X_EN   = 3'd3,
    REG_SCALE_Y_EN   = 3'd4,
    REG_SCALE_Z_EN   = 3'd5
  } cfg_reg_e;

  // taper axis codes
  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  // reset values
  localparam logic [1:0] AXIS_RST = AXIS_Z;
  localparam logic [2:0] EN_RST   = 3'b011;   // z, y, x

endpackage

// ===== rtl/point_taper_deform.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_taper_deform: linear taper of one 3D point along a chosen axis
// Ratio |c| / extent by a pipelined restoring divider, scale 1 - taper*ratio,
// per-axis scaling and a weighted blend with the original point.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Signals                         Contents
//  -------   ---------  ------------------------------  -------------------------
//  config    in         cfg_we_i, cfg_idx_i, cfg_wdata_i register writes
//  s_axis    in         tvalid, tready, tdata           pos_x, pos_y, pos_z, weight
//  m_axis    out        tvalid, tready, tdata, tuser    out_x, out_y, out_z, clamp
//
//  One point per cycle sustained while m_axis_tready holds; the pipe has three
//  input stages, a 16-stage restoring divider (one quotient bit per stage), then
//  eight stages for scale, coordinate multiply, saturation, blend multiply and final add.
//  Reset loads the register reset values and clears every stage valid bit.
//  A full stage holds only while its successor holds; empty stages close up
//  behind a stalled output, so the input keeps taking transfers until the
//  pipe fills.
//
module point_taper_deform #(
  parameter int COORD_WIDTH = ptd_pkg::COORD_WIDTH_DEF,
  localparam int IN_W  = ((3 * COORD_WIDTH + ptd_pkg::WGT_W + 7) / 8) * 8,
  localparam int OUT_W = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration writes
  input  logic                            cfg_we_i,
  input  logic [ptd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ptd_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  // input points
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [IN_W-1:0]                 s_axis_tdata,  // pos_x, pos_y, pos_z, weight
  // result points
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [OUT_W-1:0]                m_axis_tdata,  // out_x, out_y, out_z
  output logic                            m_axis_tuser   // ratio_clamped
);

  import ptd_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int CMP_W = (CW > EXT_W) ? CW : EXT_W;
  localparam int SCN_W = TR_W + 1;
  localparam int MP_W  = CW + SCALE_W;
  localparam int RND_W = MP_W - FRAC_W;
  localparam int DIF_W = CW + 1;
  localparam int BP_W  = DIF_W + WGT_W + 1;
  localparam int BR_W  = BP_W - FRAC_W;
  localparam int SUM_W = BR_W + 1;

  // stage positions
  localparam int ST_IN   = 0;
  localparam int ST_MAG  = 1;
  localparam int ST_CMP  = 2;
  localparam int ST_TR   = ST_CMP + RATIO_W + 1;
  localparam int ST_SC   = ST_TR + 1;
  localparam int ST_MUL  = ST_SC + 1;
  localparam int ST_RND  = ST_MUL + 1;
  localparam int ST_SAT  = ST_RND + 1;
  localparam int ST_BMUL = ST_SAT + 1;
  localparam int ST_BRND = ST_BMUL + 1;
  localparam int ST_OUT  = ST_BRND + 1;
  localparam int NSTG    = ST_OUT + 1;

  // point data carried alongside every stage
  typedef struct packed {
    logic [2:0][CW-1:0] p;
    logic [WGT_W-1:0]   w;
    logic               ge;
    logic               gt;
  } carry_t;

  // saturate to the signed coordinate range
  function automatic logic [CW-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-CW:0] top;
    top = v[SUM_W-1:CW-1];
    if (top == '0 || top == '1) begin
      return v[CW-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(CW-1){1'b0}}};
    end else begin
      return {1'b0, {(CW-1){1'b1}}};
    end
  endfunction

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [1:0]              axis_q;
  logic signed [AMT_W-1:0] amount_q;
  logic [EXT_W-1:0]        extent_q;
  logic [2:0]              en_q;

  // decode register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q   <= AXIS_RST;
      amount_q <= '0;
      extent_q <= '0;
      en_q     <= EN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TAPER_AXIS:   axis_q   <= cfg_wdata_i[1:0];
        REG_TAPER_AMOUNT: amount_q <= $signed(cfg_wdata_i[AMT_W-1:0]);
        REG_AXIS_EXTENT:  extent_q <= cfg_wdata_i[EXT_W-1:0];
        REG_SCALE_X_EN:   en_q[0]  <= cfg_wdata_i[0];
        REG_SCALE_Y_EN:   en_q[1]  <= cfg_wdata_i[0];
        REG_SCALE_Z_EN:   en_q[2]  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // stage flow control
  // --------------------------------------------------------------------------
  logic [NSTG-1:0] v_q;
  logic [NSTG-1:0] v_d;
  logic [NSTG:0]   adv;

  // a stage advances when empty or when its successor advances
  always_comb begin
    adv[NSTG] = m_axis_tready;
    for (int i = NSTG - 1; i >= 0; i--) begin
      adv[i] = !v_q[i] || adv[i+1];
    end
  end

  assign v_d = {v_q[NSTG-2:0], s_axis_tvalid};

  // advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int i = 0; i < NSTG; i++) begin
        if (adv[i]) begin
          v_q[i] <= v_d[i];
        end
      end
    end
  end

  assign s_axis_tready = adv[0];
  assign m_axis_tvalid = v_q[ST_OUT];

  // --------------------------------------------------------------------------
  // datapath, next values
  // --------------------------------------------------------------------------
  carry_t                  in_item;
  carry_t                  carry_q [NSTG];
  carry_t                  carry_d [NSTG];
  logic [WGT_W-1:0]        w_raw;
  logic signed [CW-1:0]    c_sel;
  logic signed [CW-1:0]    c_q;
  logic [CW-1:0]           mag_q;
  logic [CW-1:0]           mag_d;
  logic                    ge_d;
  logic                    gt_d;
  logic [EXT_W-1:0]        rem_q [RATIO_W+1];
  logic [EXT_W-1:0]        rem_d [RATIO_W+1];
  logic [RATIO_W-1:0]      quo_q [RATIO_W+1];
  logic [RATIO_W-1:0]      quo_d [RATIO_W+1];
  logic [RATIO_W:0]        ratio;
  logic signed [TR_W-1:0]  prod_tr_q;
  logic signed [SCN_W-1:0] scale_num;
  logic signed [SCALE_W-1:0] s_q;
  logic signed [MP_W-1:0]  mul_q [3];
  logic signed [RND_W-1:0] rnd_q [3];
  logic signed [DIF_W-1:0] d_q   [3];
  logic signed [DIF_W-1:0] d_d   [3];
  logic signed [BP_W-1:0]  bp_q  [3];
  logic signed [BR_W-1:0]  br_q  [3];
  logic [CW-1:0]           out_q [3];
  logic [CW-1:0]           out_d [3];
  logic                    flag_q;

  // unpack the input transfer, weight capped at one
  assign w_raw = s_axis_tdata[3*CW +: WGT_W];
  always_comb begin
    in_item    = '0;
    in_item.p  = s_axis_tdata[3*CW-1:0];
    in_item.w  = (w_raw > WGT_ONE) ? WGT_ONE : w_raw;
  end

  // pick the taper coordinate
  always_comb begin
    unique case (axis_q)
      AXIS_X:  c_sel = $signed(s_axis_tdata[0 +: CW]);
      AXIS_Y:  c_sel = $signed(s_axis_tdata[CW +: CW]);
      default: c_sel = $signed(s_axis_tdata[2*CW +: CW]);
    endcase
  end

  // magnitude and compare against the extent
  assign mag_d = c_q[CW-1] ? CW'(-c_q) : CW'(c_q);
  assign ge_d  = CMP_W'(mag_q) >= CMP_W'(extent_q);
  assign gt_d  = CMP_W'(mag_q) >  CMP_W'(extent_q);

  // pass the point along, mark the compare result
  always_comb begin
    carry_d[0] = in_item;
    for (int i = 1; i < NSTG; i++) begin
      carry_d[i] = carry_q[i-1];
    end
    carry_d[ST_CMP].ge = ge_d;
    carry_d[ST_CMP].gt = gt_d;
  end

  // restoring divider, one quotient bit per stage
  always_comb begin
    logic [EXT_W:0] rem2;
    logic [EXT_W:0] diff;
    rem_d[0] = EXT_W'(CMP_W'(mag_q));
    quo_d[0] = '0;
    for (int k = 1; k <= RATIO_W; k++) begin
      rem2 = {rem_q[k-1], 1'b0};
      diff = rem2 - {1'b0, extent_q};
      if (rem2 >= {1'b0, extent_q}) begin
        rem_d[k] = diff[EXT_W-1:0];
        quo_d[k] = {quo_q[k-1][RATIO_W-2:0], 1'b1};
      end else begin
        rem_d[k] = rem2[EXT_W-1:0];
        quo_d[k] = {quo_q[k-1][RATIO_W-2:0], 1'b0};
      end
    end
  end

  // ratio saturates at one when the coordinate reaches the extent
  assign ratio = carry_q[ST_TR-1].ge ? RATIO_ONE : {1'b0, quo_q[RATIO_W]};

  // scale = round(1 - taper * ratio) in Q.16
  assign scale_num = SCN_W'(SC_BIAS) - SCN_W'(prod_tr_q);

  // scale enabled coordinates and form the difference to the original
  always_comb begin
    logic [CW-1:0] sc;
    logic [CW-1:0] pc;
    for (int j = 0; j < 3; j++) begin
      pc = carry_q[ST_SAT-1].p[j];
      sc = en_q[j] ? sat_coord(SUM_W'(rnd_q[j])) : pc;
      d_d[j] = DIF_W'($signed(sc)) - DIF_W'($signed(pc));
    end
  end

  // add the blended difference, pass through on zero extent
  always_comb begin
    logic [CW-1:0] pc;
    for (int j = 0; j < 3; j++) begin
      pc = carry_q[ST_OUT-1].p[j];
      if (extent_q == '0) begin
        out_d[j] = pc;
      end else begin
        out_d[j] = sat_coord(SUM_W'($signed(pc)) + SUM_W'(br_q[j]));
      end
    end
  end

  // --------------------------------------------------------------------------
  // datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NSTG; i++) begin
      if (adv[i]) begin
        carry_q[i] <= carry_d[i];
      end
    end
    if (adv[ST_IN]) begin
      c_q <= c_sel;
    end
    if (adv[ST_MAG]) begin
      mag_q <= mag_d;
    end
    for (int k = 0; k <= RATIO_W; k++) begin
      if (adv[ST_CMP+k]) begin
        rem_q[k] <= rem_d[k];
        quo_q[k] <= quo_d[k];
      end
    end
    if (adv[ST_TR]) begin
      prod_tr_q <= TR_W'(amount_q) * TR_W'($signed({1'b0, ratio}));
    end
    if (adv[ST_SC]) begin
      s_q <= SCALE_W'(scale_num >>> AMT_FRAC);
    end
    for (int j = 0; j < 3; j++) begin
      if (adv[ST_MUL]) begin
        mul_q[j] <= MP_W'($signed(carry_q[ST_MUL-1].p[j])) * MP_W'(s_q);
      end
      if (adv[ST_RND]) begin
        rnd_q[j] <= RND_W'((mul_q[j] + MP_W'(HALF_LSB)) >>> FRAC_W);
      end
      if (adv[ST_SAT]) begin
        d_q[j] <= d_d[j];
      end
      if (adv[ST_BMUL]) begin
        bp_q[j] <= BP_W'(d_q[j]) * BP_W'($signed({1'b0, carry_q[ST_BMUL-1].w}));
      end
      if (adv[ST_BRND]) begin
        br_q[j] <= BR_W'((bp_q[j] + BP_W'(HALF_LSB)) >>> FRAC_W);
      end
      if (adv[ST_OUT]) begin
        out_q[j] <= out_d[j];
      end
    end
    if (adv[ST_OUT]) begin
      flag_q <= (extent_q != '0) && carry_q[ST_OUT-1].gt;
    end
  end

  assign m_axis_tdata = OUT_W'({out_q[2], out_q[1], out_q[0]});
  assign m_axis_tuser = flag_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  logic in_fire;
  logic out_fire;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  // a drained output stage leaves every stage free to advance
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty output stage");

  // items in flight change only by transfers
  a_item_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> $countones(v_q) ==
      $past($countones(v_q)) + $past(int'(in_fire)) - $past(int'(out_fire)))
    else $error("pipeline lost or duplicated an item");

  // zero extent never flags a saturated ratio
  a_zero_extent_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (extent_q == '0) |-> !m_axis_tuser)
    else $error("clamp flag raised with zero extent");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the point taper deformer
// Streams points through the block under a series of register settings.
// A short directed table comes first: pass-through after reset, coordinate
// and weight extremes, the boundary cases of the ratio and scale saturation.
// Randomised settings and points follow. Every result transfer is compared
// field by field with an in-order queue of predicted taper results.
// ----------------------------------------------------------------------------
module tb;
  import ptd_pkg::*;

  localparam int     CW           = COORD_WIDTH_DEF;
  localparam int     IN_W         = ((3 * CW + WGT_W + 7) / 8) * 8;
  localparam int     OUT_W        = ((3 * CW + 7) / 8) * 8;
  localparam int     LATENCY      = 27;
  localparam int     N_PHASES     = 10;
  localparam int     PHASE_PTS    = 115;
  localparam int     STEADY_PHASE = 4;
  localparam int     IDLE_PCT     = 10;
  localparam longint TIMEOUT_NS   = 4_000_000;
  localparam longint ONE_Q16      = 64'sd1 << FRAC_W;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // one point, x in the lowest bits
  typedef struct packed {
    logic [WGT_W-1:0] w;
    logic [CW-1:0]    z;
    logic [CW-1:0]    y;
    logic [CW-1:0]    x;
  } point_t;

  // one result, tuser on top of tdata
  typedef struct packed {
    logic          clamp;
    logic [CW-1:0] z;
    logic [CW-1:0] y;
    logic [CW-1:0] x;
  } taper_res_t;

  // one register setting; en[0] is x
  typedef struct packed {
    logic [1:0]       axis;
    logic [AMT_W-1:0] amt;
    logic [EXT_W-1:0] ext;
    logic [2:0]       en;
  } taper_cfg_t;

  typedef struct {
    int         cfg;
    point_t     pt;
    bit         typed;
    taper_res_t res;
  } dir_row_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_W-1:0]       s_axis_tdata  = '0;   // pos_x, pos_y, pos_z, weight
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_W-1:0]      m_axis_tdata;         // out_x, out_y, out_z
  logic                  m_axis_tuser;         // ratio_clamped

  taper_cfg_t cfg_now = '{axis: AXIS_RST, amt: '0, ext: '0, en: EN_RST};
  taper_res_t taper_expected [$];
  bit         steady     = 1'b0;
  int         n_err      = 0;
  int         n_points   = 0;
  int         n_results  = 0;
  int         n_clamped  = 0;
  int         n_settings = 0;

  dir_row_t   dir_tab [22];
  taper_cfg_t cfg_tab [5];

  always #10 clk_i = ~clk_i;

  point_taper_deform #(.COORD_WIDTH(CW)) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // --------------------------------------------------------------------------
  // Taper predictor
  // --------------------------------------------------------------------------

  // clip to the signed coordinate range
  function automatic longint sat_coord(longint v);
    longint hi;
    hi = (64'sd1 <<< (CW - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // Q16 product, rounded half up
  function automatic longint mul_q16(longint a, longint b);
    return (a * b + HALF_LSB) >>> FRAC_W;
  endfunction

  function automatic taper_res_t taper_point(point_t pt);
    longint     p [3];
    longint     res [3];
    longint     ext, c, mag, ratio, scale, sc, w;
    taper_res_t o;
    p[0]    = longint'($signed(pt.x));
    p[1]    = longint'($signed(pt.y));
    p[2]    = longint'($signed(pt.z));
    res     = p;
    ext     = longint'(cfg_now.ext);
    w       = (pt.w > WGT_ONE) ? ONE_Q16 : longint'(pt.w);
    o.clamp = 1'b0;
    // zero extent passes the point through
    if (ext != 0) begin
      case (cfg_now.axis)
        AXIS_X:  c = p[0];
        AXIS_Y:  c = p[1];
        default: c = p[2];   // the spare code measures along z too
      endcase
      mag = (c < 0) ? -c : c;
      if (mag >= ext) begin
        ratio   = ONE_Q16;
        o.clamp = (mag > ext);
      end else begin
        ratio = (mag <<< FRAC_W) / ext;
      end
      scale = (SC_BIAS - longint'($signed(cfg_now.amt)) * ratio) >>> AMT_FRAC;
      for (int i = 0; i < 3; i++) begin
        sc = p[i];
        if (cfg_now.en[i]) sc = sat_coord(mul_q16(p[i], scale));
        res[i] = sat_coord(p[i] + mul_q16(sc - p[i], w));
      end
    end
    o.x = CW'(res[0]);
    o.y = CW'(res[1]);
    o.z = CW'(res[2]);
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Random stimulus
  // --------------------------------------------------------------------------

  // coordinate: near the extent on the taper axis, else extremes or noise
  function automatic logic [CW-1:0] rand_coord(bit on_axis);
    int unsigned span;
    longint      m;
    if (on_axis && cfg_now.ext != 0 && $urandom_range(9, 0) < 6) begin
      span = (cfg_now.ext > 31'h3fff_ffff) ? 32'hffff_ffff : {cfg_now.ext, 1'b0};
      m = ($urandom_range(3, 0) == 0) ? longint'(cfg_now.ext)
                                      : longint'($urandom_range(span, 0));
      if ($urandom_range(1, 0) == 1) m = -m;
      return CW'(sat_coord(m));
    end
    case ($urandom_range(9, 0))
      0:       return {1'b0, {(CW-1){1'b1}}};
      1:       return {1'b1, {(CW-1){1'b0}}};
      2:       return '0;
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic point_t random_point();
    point_t pt;
    pt.x = rand_coord(cfg_now.axis == AXIS_X);
    pt.y = rand_coord(cfg_now.axis == AXIS_Y);
    pt.z = rand_coord(cfg_now.axis != AXIS_X && cfg_now.axis != AXIS_Y);
    case ($urandom_range(9, 0))
      0:       pt.w = '0;
      1:       pt.w = WGT_ONE;
      2:       pt.w = WGT_W'($urandom_range(131071, 65537));
      default: pt.w = WGT_W'($urandom_range(65536, 0));
    endcase
    return pt;
  endfunction

  function automatic taper_cfg_t random_settings();
    taper_cfg_t cs;
    cs.axis = 2'($urandom_range(3, 0));
    case ($urandom_range(5, 0))
      0:       cs.amt = 16'h8000;
      1:       cs.amt = 16'h7fff;
      2:       cs.amt = 16'h0000;
      3:       cs.amt = 16'h4000;
      default: cs.amt = AMT_W'($urandom);
    endcase
    case ($urandom_range(7, 0))
      0:       cs.ext = '0;
      1:       cs.ext = 31'd1;
      2:       cs.ext = 31'h7fff_ffff;
      3:       cs.ext = EXT_W'($urandom_range(32'h0010_0000, 1));
      default: cs.ext = EXT_W'($urandom);
    endcase
    cs.en = 3'($urandom_range(7, 0));
    return cs;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // write one register and mirror it into the predictor copy
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      REG_TAPER_AXIS:   cfg_now.axis  = data[1:0];
      REG_TAPER_AMOUNT: cfg_now.amt   = data[AMT_W-1:0];
      REG_AXIS_EXTENT:  cfg_now.ext   = data[EXT_W-1:0];
      REG_SCALE_X_EN:   cfg_now.en[0] = data[0];
      REG_SCALE_Y_EN:   cfg_now.en[1] = data[0];
      REG_SCALE_Z_EN:   cfg_now.en[2] = data[0];
      default: ;
    endcase
  endtask

  // load a full setting; junk in the unused upper bits must be ignored
  task automatic apply_settings(taper_cfg_t cs);
    write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom));
    write_reg(REG_TAPER_AXIS, {29'($urandom), cs.axis});
    write_reg(REG_TAPER_AMOUNT, {15'($urandom), cs.amt});
    write_reg(REG_AXIS_EXTENT, cs.ext);
    write_reg(REG_SCALE_X_EN, {30'($urandom), cs.en[0]});
    write_reg(REG_SCALE_Y_EN, {30'($urandom), cs.en[1]});
    write_reg(REG_SCALE_Z_EN, {30'($urandom), cs.en[2]});
    write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  // drop the input and hold until every predicted result has arrived
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (taper_expected.size() != 0) @(posedge clk_i);
  endtask

  // offer one point, idling at random first; queue its expected result
  task automatic send_point(point_t pt, bit typed, taper_res_t want);
    @(negedge clk_i);
    while (!steady && $urandom_range(99, 0) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'(pt);
    do @(posedge clk_i); while (!s_axis_tready);
    taper_expected.push_back(typed ? want : taper_point(pt));
    n_points++;
  endtask

  // result side backpressure
  always @(negedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(99, 0) >= IDLE_PCT);
  end

  // --------------------------------------------------------------------------
  // Result checker
  // --------------------------------------------------------------------------

  task automatic check_field(string name, logic [CW-1:0] want, logic [CW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      n_err++;
    end
  endtask

  // compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin
    taper_res_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata[3*CW-1:0]};
      n_results++;
      n_clamped += got.clamp;
      if (taper_expected.size() == 0) begin
        $display("%0t: result with nothing expected: expected none, got %h", $time, got);
        n_err++;
      end else begin
        want = taper_expected.pop_front();
        check_field("out_x", want.x, got.x);
        check_field("out_y", want.y, got.y);
        check_field("out_z", want.z, got.z);
        check_field("ratio_clamped", CW'(want.clamp), CW'(got.clamp));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    int applied;
    // settings 0 is the reset state and is never written
    cfg_tab = '{
      '{AXIS_RST, 16'h0000, 31'h0000_0000, EN_RST},
      '{AXIS_X,   16'h4000, 31'h0001_0000, 3'b111},
      '{AXIS_Y,   16'h8000, 31'h7fff_ffff, 3'b101},
      '{2'd3,     16'h7fff, 31'h0000_0001, 3'b010},
      '{AXIS_Z,   16'h2000, 31'h0064_0000, 3'b011}
    };
    dir_tab = '{
      // zero extent: pass-through for any weight
      '{0, '{17'd65536, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff}, 1,
           '{1'b0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff}},
      '{0, '{17'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 1,
           '{1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000}},
      '{0, '{17'd131071, 32'h0000_0000, 32'h8765_4321, 32'h1234_5678}, 1,
           '{1'b0, 32'h0000_0000, 32'h8765_4321, 32'h1234_5678}},
      '{0, '{17'd65537, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 1,
           '{1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000}},
      // taper 1.0 along x, extent 1.0: zero ratio leaves the point alone
      '{1, '{17'd65536, 32'hfffd_0000, 32'h0003_0000, 32'h0000_0000}, 1,
           '{1'b0, 32'hfffd_0000, 32'h0003_0000, 32'h0000_0000}},
      '{1, '{17'd65536, 32'h0001_0000, 32'h0002_0000, 32'h0000_8000}, 0, '0},
      '{1, '{17'd65536, 32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000}, 0, '0},
      '{1, '{17'd65536, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000}, 0, '0},
      '{1, '{17'd32768, 32'h0123_4567, 32'hfedc_ba98, 32'h8000_0000}, 0, '0},
      '{1, '{17'd131071, 32'h0005_0000, 32'hfffb_0000, 32'hffff_0000}, 0, '0},
      '{1, '{17'd0, 32'h4444_4444, 32'hbbbb_bbbb, 32'h0000_4000}, 1,
           '{1'b0, 32'h4444_4444, 32'hbbbb_bbbb, 32'h0000_4000}},
      // taper -2.0 along y, widest extent: scale near three saturates
      '{2, '{17'd65536, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff}, 0, '0},
      '{2, '{17'd65536, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000}, 0, '0},
      '{2, '{17'd20000, 32'hc000_0000, 32'h4000_0000, 32'hfedc_ba98}, 0, '0},
      // spare axis code, extent of one LSB, largest positive taper
      '{3, '{17'd65536, 32'h0000_0005, 32'h7fff_ffff, 32'h0000_0000}, 0, '0},
      '{3, '{17'd65536, 32'h0000_0000, 32'h2222_2222, 32'h1111_1111}, 0, '0},
      '{3, '{17'd65536, 32'hffff_ffff, 32'h8000_0000, 32'h0000_0000}, 0, '0},
      '{3, '{17'd1, 32'h0000_0001, 32'h4000_0000, 32'h0000_0000}, 0, '0},
      // taper 0.5 along z, extent 100.0
      '{4, '{17'd65536, 32'h0032_0000, 32'h0020_0000, 32'h0010_0000}, 0, '0},
      '{4, '{17'd49152, 32'hff9c_0000, 32'hffe0_0000, 32'h0010_0000}, 0, '0},
      '{4, '{17'd65535, 32'h0064_0001, 32'h0020_0000, 32'hfff0_0000}, 0, '0},
      '{4, '{17'd0, 32'h0000_0000, 32'h5555_5555, 32'haaaa_aaaa}, 1,
           '{1'b0, 32'h0000_0000, 32'h5555_5555, 32'haaaa_aaaa}}
    };

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    applied = 0;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].cfg != applied) begin
        wait_idle();
        apply_settings(cfg_tab[dir_tab[i].cfg]);
        applied = dir_tab[i].cfg;
      end
      send_point(dir_tab[i].pt, dir_tab[i].typed, dir_tab[i].res);
    end

    // random settings, one phase each; one phase runs without idling
    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_idle();
      apply_settings(random_settings());
      steady = (ph == STEADY_PHASE);
      repeat (PHASE_PTS) send_point(random_point(), 1'b0, '0);
    end
    steady = 1'b0;

    // drain, then watch for stray results
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    for (int k = 0; k < 50 * LATENCY && taper_expected.size() != 0; k++) begin
      @(posedge clk_i);
    end
    repeat (2 * LATENCY) @(posedge clk_i);
    while (taper_expected.size() != 0) begin
      $display("%0t: missing result: expected %h, got none", $time,
               taper_expected.pop_front());
      n_err++;
    end

    $display("Sent %0d points under %0d register settings plus reset defaults.",
             n_points, n_settings);
    $display("Checked %0d results, %0d with the ratio saturated.", n_results, n_clamped);
    if (n_err == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(TIMEOUT_NS);
    $display("Run did not complete in time.");
    $display("end of test: mismatches");
    $finish;
  end

endmodule
